### sv/spb2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spb2_pkg;

    // Screen size in pixels, 4..256 columns and 1..256 rows
    localparam logic [8:0] SCREEN_W = 9'd128;
    localparam logic [8:0] SCREEN_H = 9'd128;

    // Item kinds carried on the input tuser bit
    localparam logic OP_ATTR = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Stream widths (tdata padded to whole bytes)
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 120;

    // Input tdata field positions
    localparam int IN_ACTIVE_LSB = 0;
    localparam int IN_MIRX_LSB   = 1;
    localparam int IN_MIRY_LSB   = 2;
    localparam int IN_KEY_LSB    = 3;
    localparam int IN_POSX_LSB   = 4;
    localparam int IN_POSY_LSB   = 12;
    localparam int IN_WIDTH_LSB  = 20;
    localparam int IN_HEIGHT_LSB = 28;
    localparam int IN_PAL_LSB    = 36;
    localparam int IN_PIX_LSB    = 68;

    // Palette slot that becomes transparent in key mode
    localparam logic [1:0] KEY_SLOT = 2'd3;

    // RGB332 to RGB888: R,G scaled by 36 (x<<5 + x<<2), B by 85 (bit repeat)
    function automatic logic [23:0] expand332(input logic [7:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {c[7:5], 5'b00000} + {3'b000, c[7:5], 2'b00};
        g = {c[4:2], 5'b00000} + {3'b000, c[4:2], 2'b00};
        b = {c[1:0], c[1:0], c[1:0], c[1:0]};
        return {r, g, b};
    endfunction

    // Pick one byte of the four-entry palette
    function automatic logic [7:0] pal_pick(input logic [31:0] pal, input logic [1:0] slot);
        logic [7:0] col;
        case (slot)
            2'd0:    col = pal[7:0];
            2'd1:    col = pal[15:8];
            2'd2:    col = pal[23:16];
            default: col = pal[31:24];
        endcase
        return col;
    endfunction

endpackage

`default_nettype wire

### sv/sprite_blitter_2bpp.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Signals                      Contents
// s_axis    in   tvalid/tready/tdata/tuser    tuser = kind (attr / data byte),
//                                             tdata = sprite attributes + pixel byte
// m_axis    out  tvalid/tready/tdata/tlast    tdata = position, 4 colors, write mask,
//                                             tlast = last byte of the sprite
//
// One item per cycle while the output is taken; a result is registered and appears in the cycle after its data byte.
// The only storage is the sprite attribute/counter set and one output register.
// Reset (i_rst_n low, synchronous) drops any live sprite and empties the output.
// Input stalls only while the output register holds a result that is not taken.

module sprite_blitter_2bpp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: spr_active, mirror_x, mirror_y, key_mode, pos_x[8], pos_y[8],
    //        spr_width[8], spr_height[8], palette_word[32], pixel_byte[8], pad[4]
    input  wire logic [spb2_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser: opcode
    input  wire logic                               i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: dest_x[8], dest_y[8], rgb_a[24], rgb_b[24], rgb_c[24], rgb_d[24],
    //        write_mask[4], pad[4]
    output logic [spb2_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,
    // tlast: sprite_done
    output logic                                    o_m_axis_tlast
);

    // Sprite state
    logic        r_live;
    logic        r_flip_h;
    logic        r_flip_v;
    logic        r_key;
    logic [7:0]  r_org_x;
    logic [7:0]  r_org_y;
    logic [7:0]  r_rows;
    logic [5:0]  r_bpr;
    logic [31:0] r_pal;
    logic [7:0]  r_row;
    logic [5:0]  r_col;

    // Output register
    logic        r_out_valid;
    logic [7:0]  r_dest_x;
    logic [7:0]  r_dest_y;
    logic [23:0] r_rgb [4];
    logic [3:0]  r_mask;
    logic        r_done;

    // Input field views
    logic        in_active;
    logic        in_mir_x;
    logic        in_mir_y;
    logic        in_key;
    logic [7:0]  in_pos_x;
    logic [7:0]  in_pos_y;
    logic [7:0]  in_width;
    logic [7:0]  in_height;
    logic [31:0] in_pal;
    logic [7:0]  in_pix;

    assign in_active = i_s_axis_tdata[spb2_pkg::IN_ACTIVE_LSB];
    assign in_mir_x  = i_s_axis_tdata[spb2_pkg::IN_MIRX_LSB];
    assign in_mir_y  = i_s_axis_tdata[spb2_pkg::IN_MIRY_LSB];
    assign in_key    = i_s_axis_tdata[spb2_pkg::IN_KEY_LSB];
    assign in_pos_x  = i_s_axis_tdata[spb2_pkg::IN_POSX_LSB +: 8];
    assign in_pos_y  = i_s_axis_tdata[spb2_pkg::IN_POSY_LSB +: 8];
    assign in_width  = i_s_axis_tdata[spb2_pkg::IN_WIDTH_LSB +: 8];
    assign in_height = i_s_axis_tdata[spb2_pkg::IN_HEIGHT_LSB +: 8];
    assign in_pal    = i_s_axis_tdata[spb2_pkg::IN_PAL_LSB +: 32];
    assign in_pix    = i_s_axis_tdata[spb2_pkg::IN_PIX_LSB +: 8];

    // Handshake: take a new item whenever the output slot is free or draining
    logic in_xfer;
    logic is_attr;
    logic is_data;
    logic emit;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign is_attr = in_xfer && (i_s_axis_tuser == spb2_pkg::OP_ATTR);
    assign is_data = in_xfer && (i_s_axis_tuser == spb2_pkg::OP_DATA);
    assign emit    = is_data && r_live;

    // Attribute check: sprite must fit on screen and hold a whole byte
    logic [8:0] sum_x;
    logic [8:0] sum_y;
    logic [5:0] new_bpr;
    logic       new_live;

    assign sum_x    = {1'b0, in_pos_x} + {1'b0, in_width};
    assign sum_y    = {1'b0, in_pos_y} + {1'b0, in_height};
    assign new_bpr  = in_width[7:2];
    assign new_live = in_active && (sum_x <= spb2_pkg::SCREEN_W)
                      && (sum_y <= spb2_pkg::SCREEN_H)
                      && (new_bpr != 6'd0) && (in_height != 8'd0);

    // Destination and end-of-row / end-of-sprite detection
    logic [5:0] dcol;
    logic [7:0] drow;
    logic       col_end;
    logic       row_end;
    logic       last;
    logic [7:0] pix;

    assign dcol    = r_flip_h ? (r_bpr - 6'd1 - r_col) : r_col;
    assign drow    = r_flip_v ? (r_rows - 8'd1 - r_row) : r_row;
    assign col_end = ({1'b0, r_col} + 7'd1) >= {1'b0, r_bpr};
    assign row_end = ({1'b0, r_row} + 9'd1) >= {1'b0, r_rows};
    assign last    = col_end && row_end;
    assign pix     = r_flip_h ? {in_pix[1:0], in_pix[3:2], in_pix[5:4], in_pix[7:6]}
                              : in_pix;

    // Palette lookups and write mask, four lanes
    logic [23:0] n_rgb  [4];
    logic [3:0]  n_mask;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_rgb[k]  = spb2_pkg::expand332(spb2_pkg::pal_pick(r_pal, pix[7-2*k -: 2]));
            n_mask[k] = !(r_key && (pix[7-2*k -: 2] == spb2_pkg::KEY_SLOT));
        end
    end

    // Sprite attributes and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live   <= 1'b0;
            r_flip_h <= 1'b0;
            r_flip_v <= 1'b0;
            r_key    <= 1'b0;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_rows   <= '0;
            r_bpr    <= '0;
            r_pal    <= '0;
            r_row    <= '0;
            r_col    <= '0;
        end else if (is_attr) begin
            r_live   <= new_live;
            r_flip_h <= in_mir_x;
            r_flip_v <= in_mir_y;
            r_key    <= in_key;
            r_org_x  <= in_pos_x;
            r_org_y  <= in_pos_y;
            r_rows   <= in_height;
            r_bpr    <= new_bpr;
            r_pal    <= in_pal;
            r_row    <= '0;
            r_col    <= '0;
        end else if (emit) begin
            if (last) begin
                r_live <= 1'b0;
                r_row  <= '0;
                r_col  <= '0;
            end else if (col_end) begin
                r_col <= '0;
                r_row <= r_row + 8'd1;
            end else begin
                r_col <= r_col + 6'd1;
            end
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_dest_x <= r_org_x + {dcol, 2'b00};
            r_dest_y <= r_org_y + drow;
            r_rgb    <= n_rgb;
            r_mask   <= n_mask;
            r_done   <= last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_done;
    assign o_m_axis_tdata  = {4'b0000, r_mask, r_rgb[3], r_rgb[2], r_rgb[1], r_rgb[0],
                              r_dest_y, r_dest_x};

    // Checks
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_drop_not_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_data && !r_live && i_m_axis_tready) |=> !o_m_axis_tvalid)
        else $error("result produced for a dropped byte");

    a_attr_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_attr |=> (r_row == 8'd0) && (r_col == 6'd0))
        else $error("counters not restarted by attribute load");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last) |=> !r_live && o_m_axis_tlast)
        else $error("sprite still live after its last byte");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live |-> (r_col < r_bpr) && (r_row < r_rows))
        else $error("counter beyond sprite size");

endmodule

`default_nettype wire
